/* hw/rtl/frwl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwl_pkg
// Shared types and constants for the fork rate window limiter.
// ----------------------------------------------------------------------------
package frwl_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int NOW_W        = 64;
  localparam int WS_W         = 6;
  localparam int SEP_W        = 32;
  localparam int NS_W         = 30;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W        = (CNT_W > WS_W) ? CNT_W : WS_W;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic [NS_W-1:0] NS_PER_SECOND = NS_W'(1000000000);

  // Register index, taken from paddr[2].
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_SEPARATION  = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_IGNORED  = 2'd0,
    VERDICT_RECORDED = 2'd1,
    VERDICT_SLID     = 2'd2,
    VERDICT_KILLED   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic load_now;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] eff_window;
    logic [NOW_W-1:0] limit_ns;
  } cfg_t;

endpackage

/* hw/rtl/frwl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwl_cell
// One timestamp slot of the window log; takes the new stamp or its upper
// neighbor's stamp.
// ----------------------------------------------------------------------------
module frwl_cell (
  input  logic                        clk,
  input  frwl_pkg::cell_ctrl_t        ctrl,
  input  logic [frwl_pkg::NOW_W-1:0]  now_ns,
  input  logic [frwl_pkg::NOW_W-1:0]  neighbor_stamp,
  output logic [frwl_pkg::NOW_W-1:0]  stamp
);

  logic [frwl_pkg::NOW_W-1:0] stamp_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_now) begin
      stamp_r <= now_ns;
    end else if (ctrl.shift) begin
      stamp_r <= neighbor_stamp;
    end
  end

  assign stamp = stamp_r;

endmodule

/* hw/rtl/frwl_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwl_regs
// Configuration registers behind the APB port, with the clamped window size
// and the separation limit in nanoseconds.
// ----------------------------------------------------------------------------
module frwl_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [frwl_pkg::APB_AW-1:0]  paddr,
  input  logic [frwl_pkg::APB_DW-1:0]  pwdata,
  output logic [frwl_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output frwl_pkg::cfg_t               cfg
);

  logic [frwl_pkg::WS_W-1:0]          window_size_r;
  logic [frwl_pkg::SEP_W-1:0]         separation_r;
  logic [frwl_pkg::NOW_W-1:0]         limit_r;
  logic [frwl_pkg::SEP_W+frwl_pkg::NS_W-1:0] product;
  logic [frwl_pkg::CMP_W-1:0]         ws_ext;
  logic                               wr_en;
  logic                               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // The product is formed straight from the write data so the limit register
  // is loaded by the same transfer as the separation.
  assign product = {{frwl_pkg::NS_W{1'b0}}, pwdata[frwl_pkg::SEP_W-1:0]} *
                   {{frwl_pkg::SEP_W{1'b0}}, frwl_pkg::NS_PER_SECOND};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= frwl_pkg::WS_W'(1);
      separation_r  <= '0;
      limit_r       <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        frwl_pkg::REG_WINDOW_SIZE: begin
          window_size_r <= pwdata[frwl_pkg::WS_W-1:0];
        end
        frwl_pkg::REG_SEPARATION: begin
          separation_r <= pwdata[frwl_pkg::SEP_W-1:0];
          limit_r      <= frwl_pkg::NOW_W'(product);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      frwl_pkg::REG_WINDOW_SIZE: prdata = frwl_pkg::APB_DW'(window_size_r);
      frwl_pkg::REG_SEPARATION:  prdata = frwl_pkg::APB_DW'(separation_r);
      default:                   prdata = '0;
    endcase
  end

  assign ws_ext = frwl_pkg::CMP_W'(window_size_r);

  always_comb begin
    if (ws_ext == '0) begin
      cfg.eff_window = frwl_pkg::CNT_W'(1);
    end else if (ws_ext > frwl_pkg::CMP_W'(frwl_pkg::WINDOW_DEPTH)) begin
      cfg.eff_window = frwl_pkg::CNT_W'(frwl_pkg::WINDOW_DEPTH);
    end else begin
      cfg.eff_window = frwl_pkg::CNT_W'(ws_ext);
    end
    cfg.limit_ns = limit_r;
  end

endmodule

/* hw/rtl/frwl_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwl_skid
// Output register with a skid stage for the verdict channel.
// ----------------------------------------------------------------------------
module frwl_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  frwl_pkg::verdict_t  push_verdict,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_verdict
);

  logic               main_valid_r;
  logic               main_valid_nxt;
  frwl_pkg::verdict_t main_r;
  frwl_pkg::verdict_t main_nxt;
  logic               skid_valid_r;
  logic               skid_valid_nxt;
  frwl_pkg::verdict_t skid_r;
  frwl_pkg::verdict_t skid_nxt;
  logic               pop;

  assign pop = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    main_nxt       = main_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_verdict;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full        = skid_valid_r;
  assign out_valid   = main_valid_r;
  assign out_verdict = main_r;

endmodule

/* hw/rtl/fork_rate_window_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fork_rate_window_limiter
// Sliding-window-log rate limiter: a row of timestamp cells with a verdict
// per event.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_now_ns, in_name_matches, in_is_child
// out      output     out_valid/out_stall out_verdict
// cfg      input      APB psel/penable    paddr, pwdata, prdata
//
// One event is taken per cycle unless in_stall is high; its verdict enters the
// output register, or the skid stage on a stall. Decision and cell update are in
// the same cycle, bounded by 64-bit subtract and compare against the oldest cell.
// Reset clears the fill count, the output stages and the registers; the cells
// hold no state that is read before it is written.
// in_stall rises only when the skid stage is occupied by a stalled result.
// ----------------------------------------------------------------------------
module fork_rate_window_limiter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [63:0]                  in_now_ns,
  input  logic                         in_name_matches,
  input  logic                         in_is_child,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_verdict,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [frwl_pkg::APB_AW-1:0]  paddr,
  input  logic [frwl_pkg::APB_DW-1:0]  pwdata,
  output logic [frwl_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  frwl_pkg::cfg_t             cfg;
  logic [frwl_pkg::CNT_W-1:0] count_r;
  logic [frwl_pkg::CNT_W-1:0] count_nxt;
  logic [frwl_pkg::CNT_W-1:0] last_slot;
  logic [frwl_pkg::NOW_W-1:0] stamps [frwl_pkg::WINDOW_DEPTH];
  logic [frwl_pkg::NOW_W-1:0] age;
  logic                       accept;
  logic                       counts;
  logic                       filling;
  logic                       too_soon;
  logic                       record;
  logic                       slide;
  logic                       skid_full;
  frwl_pkg::verdict_t         verdict;

  frwl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall  = skid_full;
  assign accept    = in_valid && !skid_full;
  assign counts    = in_name_matches && in_is_child;
  assign filling   = count_r < cfg.eff_window;
  assign age       = in_now_ns - stamps[0];
  assign too_soon  = age < cfg.limit_ns;
  assign record    = accept && counts && filling;
  assign slide     = accept && counts && !filling && !too_soon;
  assign last_slot = cfg.eff_window - frwl_pkg::CNT_W'(1);
  assign count_nxt = record ? count_r + frwl_pkg::CNT_W'(1) : count_r;

  always_comb begin
    if (!counts) begin
      verdict = frwl_pkg::VERDICT_IGNORED;
    end else if (filling) begin
      verdict = frwl_pkg::VERDICT_RECORDED;
    end else if (too_soon) begin
      verdict = frwl_pkg::VERDICT_KILLED;
    end else begin
      verdict = frwl_pkg::VERDICT_SLID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // On a slide every cell below the last active slot takes its neighbor's
  // stamp and the last active slot takes the new one.
  for (genvar i = 0; i < frwl_pkg::WINDOW_DEPTH; i++) begin : g_cell
    frwl_pkg::cell_ctrl_t       ctrl;
    logic [frwl_pkg::NOW_W-1:0] neighbor;

    assign ctrl.load_now = (record && (count_r == frwl_pkg::CNT_W'(i))) ||
                           (slide && (last_slot == frwl_pkg::CNT_W'(i)));
    assign ctrl.shift    = slide && (frwl_pkg::CNT_W'(i) < last_slot);

    if (i == frwl_pkg::WINDOW_DEPTH - 1) begin : g_top
      assign neighbor = '0;
    end else begin : g_mid
      assign neighbor = stamps[i+1];
    end

    frwl_cell u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .now_ns         (in_now_ns),
      .neighbor_stamp (neighbor),
      .stamp          (stamps[i])
    );
  end

  frwl_skid u_skid (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (accept),
    .push_verdict (verdict),
    .full         (skid_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_verdict  (out_verdict)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fork rate window limiter. Events are sent in
// random bursts while the verdict side stalls on its own pattern. Every
// transfer on the event side runs through an in-bench predictor of the
// timestamp log, and each verdict transfer is checked against the oldest
// pending prediction. Register writes happen only with the block idle.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [frwl_pkg::APB_AW-1:0] ADDR_WINDOW_SIZE =
    {frwl_pkg::REG_WINDOW_SIZE, 2'b00};
  localparam logic [frwl_pkg::APB_AW-1:0] ADDR_SEPARATION  =
    {frwl_pkg::REG_SEPARATION, 2'b00};
  localparam logic [63:0] NS_PER_SEC  = 64'(frwl_pkg::NS_PER_SECOND);
  localparam int          MAX_REPORTS = 10;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [63:0]                 in_now_ns;
  logic                        in_name_matches;
  logic                        in_is_child;
  logic                        out_valid;
  logic                        out_stall;
  logic [1:0]                  out_verdict;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [frwl_pkg::APB_AW-1:0] paddr;
  logic [frwl_pkg::APB_DW-1:0] pwdata;
  logic [frwl_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  // Predictor state: the timestamp log and its register copies.
  logic [63:0]       stamp_log [frwl_pkg::WINDOW_DEPTH];
  int unsigned       log_count;
  logic [5:0]        win_size_reg;
  logic [31:0]       sep_reg;

  frwl_pkg::verdict_t pending_verdicts [$];
  frwl_pkg::verdict_t expected_verdict;
  logic [63:0]       event_clock;
  int                burst_left;
  bit                no_gaps;
  int                hold_len;
  int                error_count;
  int                events_sent;
  int                verdicts_checked;
  int                records_seen;
  int                kills_seen;
  int                slides_seen;
  int                input_stall_cycles;

  fork_rate_window_limiter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_now_ns       (in_now_ns),
    .in_name_matches (in_name_matches),
    .in_is_child     (in_is_child),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_verdict     (out_verdict),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Out-of-range window sizes are clamped into 1..WINDOW_DEPTH.
  function automatic int unsigned window_span();
    if (win_size_reg == 6'd0) return 1;
    if (win_size_reg > frwl_pkg::WINDOW_DEPTH) return frwl_pkg::WINDOW_DEPTH;
    return 32'(win_size_reg);
  endfunction

  function automatic frwl_pkg::verdict_t judge_event(input logic [63:0] now,
                                                     input logic nm, input logic ic);
    int unsigned span;
    logic [63:0] limit_ns;
    if (!(nm && ic)) return frwl_pkg::VERDICT_IGNORED;
    span = window_span();
    if (log_count < span) begin
      stamp_log[log_count] = now;
      log_count++;
      records_seen++;
      return frwl_pkg::VERDICT_RECORDED;
    end
    limit_ns = 64'(sep_reg) * NS_PER_SEC;
    if (now - stamp_log[0] < limit_ns) begin
      kills_seen++;
      return frwl_pkg::VERDICT_KILLED;
    end
    for (int i = 0; i + 1 < span; i++) stamp_log[i] = stamp_log[i + 1];
    stamp_log[span - 1] = now;
    slides_seen++;
    return frwl_pkg::VERDICT_SLID;
  endfunction

  // Mostly forward steps; now and then a jump anywhere or a step backward.
  function automatic logic [63:0] advance_clock(input logic [63:0] step_max);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) event_clock = rand64();
    else if (pick < 5) event_clock = event_clock - (rand64() % (step_max + 1));
    else event_clock = event_clock + (rand64() % (step_max + 1));
    return event_clock;
  endfunction

  task automatic send_event(input logic [63:0] now, input logic nm, input logic ic);
    int gap;
    if (burst_left == 0 && !no_gaps) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid        <= 1'b1;
    in_now_ns       <= now;
    in_name_matches <= nm;
    in_is_child     <= ic;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(judge_event(now, nm, ic));
    events_sent++;
    if (burst_left != 0) burst_left--;
  endtask

  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [frwl_pkg::APB_AW-1:0] addr,
                           input logic [31:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_WINDOW_SIZE) win_size_reg = data[5:0];
    else sep_reg = data;
  endtask

  task automatic read_check(input logic [frwl_pkg::APB_AW-1:0] addr,
                            input logic [31:0] want);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("ERROR: register at 0x%0h read 0x%08h, expected 0x%08h",
                 addr, prdata, want);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_access();
    read_check(ADDR_WINDOW_SIZE, 32'd1);
    read_check(ADDR_SEPARATION, 32'd0);
    // Upper bits of the window size write must be dropped.
    write_reg(ADDR_WINDOW_SIZE, 32'hFFFF_FFE5);
    read_check(ADDR_WINDOW_SIZE, 32'h0000_0025);
    write_reg(ADDR_SEPARATION, 32'hFFFF_FFFF);
    read_check(ADDR_SEPARATION, 32'hFFFF_FFFF);
    write_reg(ADDR_WINDOW_SIZE, 32'd1);
    write_reg(ADDR_SEPARATION, 32'd0);
  endtask

  task automatic test_ignored_events();
    send_event(64'd0, 1'b0, 1'b0);
    send_event({64{1'b1}}, 1'b0, 1'b1);
    send_event({64{1'b1}}, 1'b1, 1'b0);
    send_event(64'hA5A5_5A5A_F00F_0FF0, 1'b0, 1'b0);
  endtask

  task automatic test_first_window();
    write_reg(ADDR_SEPARATION, 32'd1);
    send_event(64'd100, 1'b1, 1'b1);
    send_event(64'd500_000_000, 1'b1, 1'b1);
    send_event(64'd1_000_000_100, 1'b1, 1'b1);
    send_event(64'd2_000_000_099, 1'b1, 1'b1);
    send_event({64{1'b1}} - 64'd10, 1'b1, 1'b1);
    // The difference wraps around zero and lands inside the interval.
    send_event(64'd5, 1'b1, 1'b1);
  endtask

  task automatic test_window_limits();
    write_reg(ADDR_WINDOW_SIZE, 32'd0);
    write_reg(ADDR_SEPARATION, 32'd0);
    send_event(64'd1000, 1'b1, 1'b1);
    send_event(64'd0, 1'b1, 1'b1);
    write_reg(ADDR_WINDOW_SIZE, 32'd63);
    write_reg(ADDR_SEPARATION, 32'hFFFF_FFFF);
    send_event(64'd7, 1'b1, 1'b1);
    send_event(64'h8000_0000_0000_0000, 1'b1, 1'b1);
    send_event(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    event_clock = 64'h8000_0000_0000_0000;
  endtask

  task automatic run_phase(input logic [5:0] win, input logic [31:0] sep, input int count);
    logic [63:0] step_max;
    logic [31:0] junk;
    logic        nm;
    logic        ic;
    int          counted;
    junk = $urandom();
    write_reg(ADDR_WINDOW_SIZE, {junk[31:6], win});
    write_reg(ADDR_SEPARATION, sep);
    // Space the events so that kills and slides both turn up often.
    if (sep == 32'd0) step_max = 64'd5000;
    else step_max = (64'(sep) * NS_PER_SEC * 64'd2) / window_span();
    counted = 0;
    while (counted < count) begin
      if ($urandom_range(0, 99) < 85) {nm, ic} = 2'b11;
      else {nm, ic} = 2'($urandom_range(0, 3));
      if (nm && ic) counted++;
      send_event(advance_clock(step_max), nm, ic);
    end
  endtask

  task automatic test_random_windows();
    run_phase(6'd1, 32'd0, 60);
    run_phase(6'd4, 32'd1, 140);
    run_phase(6'd2, 32'd1, 80);   // shrink below the fill count
    run_phase(6'd8, 32'd1, 120);  // grow again, filling resumes
    run_phase(6'd0, 32'd2, 60);
    run_phase(6'd32, 32'd1, 120);
    run_phase(6'd63, 32'd1, 150);
    run_phase(6'd3, 32'hFFFF_FFFF, 80);
    run_phase(6'd16, 32'd3, 120);
    wait_idle();
  endtask

  // The verdict side holds off for a long stretch while events keep coming.
  task automatic test_backpressure();
    write_reg(ADDR_WINDOW_SIZE, 32'd4);
    write_reg(ADDR_SEPARATION, 32'd1);
    no_gaps  = 1'b1;
    hold_len = 300;
    repeat (50) send_event(advance_clock(64'd500_000_000), 1'b1, 1'b1);
    no_gaps = 1'b0;
    wait_idle();
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int          stretch;
    int          held;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      mode    = stall_mode_t'($urandom_range(0, 3));
      stretch = $urandom_range(4, 50);
      repeat (stretch) begin
        if (hold_len != 0) begin
          held     = hold_len;
          hold_len = 0;
          repeat (held) begin
            out_stall <= 1'b1;
            @(posedge clk);
          end
        end
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
          default:     out_stall <= ~out_stall;
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: verdict %0d at %0t with no event pending",
                   out_verdict, $realtime);
      end else begin
        expected_verdict = pending_verdicts.pop_front();
        verdicts_checked++;
        if (out_verdict !== expected_verdict) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: verdict mismatch at %0t: expected %s (%0d), got %0d",
                     $realtime, expected_verdict.name(), expected_verdict, out_verdict);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("ERROR: run timed out with %0d verdicts pending", pending_verdicts.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_now_ns       <= 64'd0;
    in_name_matches <= 1'b0;
    in_is_child     <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    win_size_reg       = 6'd1;
    sep_reg            = 32'd0;
    log_count          = 0;
    event_clock        = 64'd0;
    burst_left         = 0;
    no_gaps            = 1'b0;
    hold_len           = 0;
    error_count        = 0;
    events_sent        = 0;
    verdicts_checked   = 0;
    records_seen       = 0;
    kills_seen         = 0;
    slides_seen        = 0;
    input_stall_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_ignored_events();
    test_first_window();
    test_window_limits();
    test_random_windows();
    test_backpressure();

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      error_count += pending_verdicts.size();
      $display("ERROR: %0d verdicts never arrived", pending_verdicts.size());
    end
    $display("Sent %0d events over nine window settings; checked %0d verdicts",
             events_sent, verdicts_checked);
    $display("Recorded %0d, slid %0d, killed %0d; input held off on %0d cycles",
             records_seen, slides_seen, kills_seen, input_stall_cycles);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/frwl_pkg.sv
hw/rtl/frwl_cell.sv
hw/rtl/frwl_regs.sv
hw/rtl/frwl_skid.sv
hw/rtl/fork_rate_window_limiter.sv
test/testbench.sv
